// ===== rtl/bapc_pkg.sv =====
// ============================================================================
// bapc_pkg
// Shared types and constants for the bit-aligned pattern counter.
// ============================================================================
package bapc_pkg;

    localparam int BYTE_BITS              = 8;
    localparam int OP_WIDTH               = 2;
    localparam int LEN_WIDTH              = 9;
    localparam int HITS_WIDTH             = 4;
    localparam int MIN_LEN                = 16;
    localparam int PATTERN_MAX_BITS_DEF   = 256;
    localparam int COUNT_WIDTH_DEF        = 32;

    localparam logic [LEN_WIDTH-1:0] LEN_RESET = LEN_WIDTH'(MIN_LEN);

    // Request opcodes carried on s_tuser
    typedef enum logic [OP_WIDTH-1:0] {
        OP_LOAD_PATTERN  = 2'd0,
        OP_TEXT          = 2'd1,
        OP_CLEAR_TEXT    = 2'd2,
        OP_CLEAR_PATTERN = 2'd3
    } op_t;

endpackage

// ===== rtl/bit_aligned_pattern_counter_core.sv =====
// ============================================================================
// bit_aligned_pattern_counter_core
// Counts bit-aligned occurrences of a loaded pattern in a byte stream.
// ============================================================================
// The core takes one request per cycle on the s_* stream while the result
// side is not stalled. A text request (op 1) yields exactly one result on
// m_* through two register stages: the history shifts in at acceptance, the
// eight windows ending in that byte are compared from stage 1 and the result
// lands in the output register. Load-pattern, clear-text and clear-pattern
// requests take effect at acceptance and yield no result; a pattern clear
// zeroes the whole store. Sustained rate is one request per cycle while
// m_tready holds; the stage-1 path is the 8 x PATTERN_MAX_BITS compare, an
// AND tree, a popcount and the COUNT_WIDTH-bit saturating add. The pattern
// length (cfg_data) may be changed only while no text request is in flight;
// it is clamped to 16..PATTERN_MAX_BITS. Pattern bytes never written since
// reset must not fall inside the active length.
module bit_aligned_pattern_counter_core #(
    parameter int PATTERN_MAX_BITS = bapc_pkg::PATTERN_MAX_BITS_DEF,
    parameter int COUNT_WIDTH      = bapc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write: pattern_length_bits
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bapc_pkg::LEN_WIDTH-1:0]     cfg_data,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bapc_pkg::BYTE_BITS-1:0]     s_tdata,   // [7:0] byte_value
    input  logic [bapc_pkg::OP_WIDTH-1:0]      s_tuser,   // [1:0] op
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [3:0] matches_in_byte, [COUNT_WIDTH+3:4] total_matches, zero pad above
    output logic [((bapc_pkg::HITS_WIDTH + COUNT_WIDTH + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int BB        = bapc_pkg::BYTE_BITS;
    localparam int PAT_BYTES = (PATTERN_MAX_BITS + BB - 1) / BB;
    localparam int PAT_BITS  = PAT_BYTES * BB;
    localparam int HIST_BYTES = PAT_BYTES + 1;
    localparam int HIST_BITS = HIST_BYTES * BB;
    localparam int IDX_W     = $clog2(PAT_BYTES);
    localparam int PTR_W     = $clog2(PAT_BYTES + 1);
    localparam int LW        = $clog2(PATTERN_MAX_BITS + 1);       // length / bit count
    localparam int LCMP      = (bapc_pkg::LEN_WIDTH > LW) ? bapc_pkg::LEN_WIDTH : LW;
    localparam int SW        = $clog2(PAT_BITS + 1);
    localparam int HW        = bapc_pkg::HITS_WIDTH;
    localparam int OUT_W     = ((HW + COUNT_WIDTH + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic                   s1_valid_reg, s1_valid_next;
    logic [LW-1:0]          s1_before_reg, s1_before_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HW-1:0]          out_hits_reg, out_hits_next;
    logic [COUNT_WIDTH-1:0] out_total_reg, out_total_next;

    logic          accept;
    logic          advance;
    bapc_pkg::op_t op;

    assign op        = bapc_pkg::op_t'(s_tuser);
    assign advance   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration: pattern length, clamped and registered with the
    // aligned pattern
    // ------------------------------------------------------------------
    logic [bapc_pkg::LEN_WIDTH-1:0] len_reg, len_next;
    logic [LCMP-1:0]                len_wide;
    logic [LW-1:0]                  len_eff_next, len_eff_reg;

    always_comb
    begin
        len_next = len_reg;
        if (cfg_valid && cfg_ready)
        begin
            len_next = cfg_data;
        end
        len_wide = LCMP'(len_next);
        if (len_wide < LCMP'(bapc_pkg::MIN_LEN))
        begin
            len_wide = LCMP'(bapc_pkg::MIN_LEN);
        end
        else if (len_wide > LCMP'(PATTERN_MAX_BITS))
        begin
            len_wide = LCMP'(PATTERN_MAX_BITS);
        end
        len_eff_next = len_wide[LW-1:0];
    end

    // ------------------------------------------------------------------
    // Pattern store and its reversed, length-aligned image
    // ------------------------------------------------------------------
    logic [BB-1:0]       pat_reg  [PAT_BYTES];
    logic [BB-1:0]       pat_next [PAT_BYTES];
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [PAT_BITS-1:0] pat_rev;
    logic [SW-1:0]       shamt;
    logic [PAT_BITS-1:0] aligned_reg, aligned_next;
    logic [PAT_BITS-1:0] mask_reg, mask_next;

    always_comb
    begin
        pat_next = pat_reg;
        ptr_next = ptr_reg;
        if (accept)
        begin
            unique case (op)
                bapc_pkg::OP_LOAD_PATTERN:
                begin
                    if (ptr_reg < PTR_W'(PAT_BYTES))
                    begin
                        pat_next[ptr_reg[IDX_W-1:0]] = s_tdata;
                        ptr_next = ptr_reg + PTR_W'(1);
                    end
                end
                bapc_pkg::OP_CLEAR_PATTERN:
                begin
                    for (int s = 0; s < PAT_BYTES; s++)
                    begin
                        pat_next[s] = '0;
                    end
                    ptr_next = '0;
                end
                bapc_pkg::OP_TEXT,
                bapc_pkg::OP_CLEAR_TEXT:
                begin
                    ptr_next = ptr_reg;
                end
                default:
                begin
                    ptr_next = ptr_reg;
                end
            endcase
        end
    end

    // Byte slot s of the reversed image holds pattern byte PAT_BYTES-1-s,
    // bit order unchanged; shifting it right by PAT_BITS-L puts the last
    // pattern bit at position 0, matching the newest window bit.
    always_comb
    begin
        for (int s = 0; s < PAT_BYTES; s++)
        begin
            pat_rev[s*BB +: BB] = pat_next[PAT_BYTES-1-s];
        end
        shamt        = SW'(PAT_BITS) - SW'(len_eff_next);
        aligned_next = pat_rev >> shamt;
        mask_next    = ~({PAT_BITS{1'b1}} << len_eff_next);
    end

    // ------------------------------------------------------------------
    // Text history and received-bit count
    // ------------------------------------------------------------------
    logic [BB-1:0]  hist_reg [HIST_BYTES];
    logic [LW-1:0]  bits_reg, bits_next;
    logic [LW:0]    bits_sum;

    always_comb
    begin
        bits_next      = bits_reg;
        s1_before_next = s1_before_reg;
        bits_sum       = {1'b0, bits_reg} + (LW+1)'(BB);
        if (accept && (op == bapc_pkg::OP_TEXT))
        begin
            s1_before_next = bits_reg;
            if (bits_sum > (LW+1)'(PATTERN_MAX_BITS))
            begin
                bits_next = LW'(PATTERN_MAX_BITS);
            end
            else
            begin
                bits_next = bits_sum[LW-1:0];
            end
        end
        else if (accept && (op == bapc_pkg::OP_CLEAR_TEXT))
        begin
            bits_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // Window compare: window j ends at bit 7-j of the newest byte.
    // A window counts only once L bits have arrived since the last clear.
    // ------------------------------------------------------------------
    logic [HIST_BITS-1:0]   text_vec;
    logic [PAT_BITS-1:0]    win;
    logic [BB-1:0]          hit_vec;
    logic [HW-1:0]          hits;
    logic [COUNT_WIDTH:0]   total_sum;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] total_sat;

    always_comb
    begin
        for (int s = 0; s < HIST_BYTES; s++)
        begin
            text_vec[s*BB +: BB] = hist_reg[s];
        end
        for (int j = 0; j < BB; j++)
        begin
            win        = text_vec[(BB-1-j) +: PAT_BITS];
            hit_vec[j] = (&(~(win ^ aligned_reg) | ~mask_reg))
                         && (({1'b0, s1_before_reg} + (LW+1)'(j + 1))
                             >= {1'b0, len_eff_reg});
        end
        hits = '0;
        for (int j = 0; j < BB; j++)
        begin
            hits = hits + HW'(hit_vec[j]);
        end
        total_sum = {1'b0, total_reg} + (COUNT_WIDTH+1)'(hits);
        total_sat = total_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                           : total_sum[COUNT_WIDTH-1:0];
    end

    // ------------------------------------------------------------------
    // Stage control, running total, output register
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_hits_next  = out_hits_reg;
        out_total_next = out_total_reg;
        total_next     = total_reg;

        if (advance)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            out_hits_next  = hits;
            out_total_next = total_sat;
            total_next     = total_sat;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept && (op == bapc_pkg::OP_TEXT))
        begin
            s1_valid_next = 1'b1;
        end
        // a clear accepted with an older text request leaving stage 1
        // lands after that request's update
        if (accept && (op == bapc_pkg::OP_CLEAR_TEXT))
        begin
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= bapc_pkg::LEN_RESET;
            len_eff_reg   <= LW'(bapc_pkg::MIN_LEN);
            ptr_reg       <= '0;
            bits_reg      <= '0;
            total_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            len_eff_reg   <= len_eff_next;
            ptr_reg       <= ptr_next;
            bits_reg      <= bits_next;
            total_reg     <= total_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pat_reg       <= pat_next;
        aligned_reg   <= aligned_next;
        mask_reg      <= mask_next;
        s1_before_reg <= s1_before_next;
        out_hits_reg  <= out_hits_next;
        out_total_reg <= out_total_next;
        if (accept && (op == bapc_pkg::OP_TEXT))
        begin
            hist_reg[0] <= s_tdata;
            for (int s = 1; s < HIST_BYTES; s++)
            begin
                hist_reg[s] <= hist_reg[s-1];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_total_reg, out_hits_reg});

endmodule

// ===== verif/bit_aligned_pattern_counter_core_test.sv =====
// ----------------------------------------------------------------------------
// bit_aligned_pattern_counter_core_test
// Self-checking bench for the bit-aligned pattern counter. A directed table
// covers reset behavior, the length clamps, the short-history rule and the
// per-byte count extremes. Random phases then load patterns, embed them at
// arbitrary bit offsets in text, and mix in near misses and stray requests.
// Every result is checked against a cycle-free predictor of the core.
// ----------------------------------------------------------------------------
module bit_aligned_pattern_counter_core_test;

    localparam int PATTERN_MAX_BITS = bapc_pkg::PATTERN_MAX_BITS_DEF;
    localparam int COUNT_W          = bapc_pkg::COUNT_WIDTH_DEF;
    localparam int BYTE_BITS        = bapc_pkg::BYTE_BITS;
    localparam int OP_WIDTH         = bapc_pkg::OP_WIDTH;
    localparam int LEN_WIDTH        = bapc_pkg::LEN_WIDTH;
    localparam int HITS_WIDTH       = bapc_pkg::HITS_WIDTH;
    localparam int MIN_LEN          = bapc_pkg::MIN_LEN;
    localparam int PAT_BYTES        = PATTERN_MAX_BITS / BYTE_BITS;
    localparam int HIST_BITS        = PATTERN_MAX_BITS + BYTE_BITS;
    localparam int RESULT_BITS      = ((HITS_WIDTH + COUNT_W + 7) / 8) * 8;
    localparam int DRAIN_CYCLES     = 4;      // two register stages plus margin
    localparam int RANDOM_ITEMS     = 850;
    localparam int QUIET_AFTER      = 760;    // no idling in the tail of the run
    localparam int LIMIT_CYCLES     = 500000;
    localparam int NUM_ROWS         = 25;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [LEN_WIDTH-1:0]   cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_BITS-1:0]   s_tdata;    // [7:0] byte_value
    logic [OP_WIDTH-1:0]    s_tuser;    // [1:0] op
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RESULT_BITS-1:0] m_tdata;    // [3:0] matches_in_byte, [35:4] total_matches

    bit_aligned_pattern_counter_core #(
        .PATTERN_MAX_BITS (PATTERN_MAX_BITS),
        .COUNT_WIDTH      (COUNT_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    typedef struct {
        logic [HITS_WIDTH-1:0] hits;
        logic [COUNT_W-1:0]    total;
    } count_result_t;

    typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

    // cfg rows use value as the length; op is ignored there
    typedef struct {
        row_kind_t             kind;
        bapc_pkg::op_t         op;
        int unsigned           value;
        bit                    fixed;
        logic [HITS_WIDTH-1:0] hits;
        logic [COUNT_W-1:0]    total;
    } stim_row_t;

    // predicted core state
    logic [7:0]           pattern_bytes [PAT_BYTES];
    int unsigned          pattern_ptr;
    logic [HIST_BITS-1:0] text_window;     // newest text byte in the low bits
    int unsigned          bits_seen;
    logic [COUNT_W-1:0]   occurrence_total;
    logic [LEN_WIDTH-1:0] length_reg;

    count_result_t pending_counts [$];

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned random_items;
    int unsigned text_sent;
    int unsigned matches_seen;
    int unsigned length_writes;
    int unsigned phases;
    bit          sender_idles;
    bit          receiver_idles;
    bit          quiet;
    int unsigned stall_left;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // pattern FF 00 at the reset length of 16
        '{ROW_REQ, bapc_pkg::OP_LOAD_PATTERN,  8'hFF, 1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_LOAD_PATTERN,  8'h00, 1'b0, 4'd0, 32'd0},
        // first byte: history too short for any window
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'hFF, 1'b1, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'h00, 1'b1, 4'd1, 32'd1},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'hFF, 1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'h00, 1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_CLEAR_TEXT,    8'h00, 1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'h00, 1'b1, 4'd0, 32'd0},
        // cleared pattern reads as zeros: all-zero text hits every offset with a full window
        '{ROW_REQ, bapc_pkg::OP_CLEAR_PATTERN, 8'h00, 1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'h00, 1'b1, 4'd1, 32'd1},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'h00, 1'b1, 4'd8, 32'd9},
        '{ROW_CFG, bapc_pkg::OP_TEXT,          0,     1'b0, 4'd0, 32'd0},  // clamps up to 16
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'h00, 1'b1, 4'd8, 32'd17},
        '{ROW_CFG, bapc_pkg::OP_TEXT,          511,   1'b0, 4'd0, 32'd0},  // clamps down to max
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'hFF, 1'b1, 4'd0, 32'd17},
        '{ROW_REQ, bapc_pkg::OP_LOAD_PATTERN,  8'h80, 1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_LOAD_PATTERN,  8'h01, 1'b0, 4'd0, 32'd0},
        '{ROW_CFG, bapc_pkg::OP_TEXT,          15,    1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'h80, 1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'h01, 1'b0, 4'd0, 32'd0},
        '{ROW_CFG, bapc_pkg::OP_TEXT,          256,   1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'h00, 1'b0, 4'd0, 32'd0},
        '{ROW_CFG, bapc_pkg::OP_TEXT,          257,   1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_CLEAR_TEXT,    8'h00, 1'b0, 4'd0, 32'd0},
        '{ROW_REQ, bapc_pkg::OP_TEXT,          8'hFF, 1'b1, 4'd0, 32'd0}
    };

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned active_length();
        int unsigned len;
        len = length_reg;
        if (len < MIN_LEN)
        begin
            len = MIN_LEN;
        end
        if (len > PATTERN_MAX_BITS)
        begin
            len = PATTERN_MAX_BITS;
        end
        return len;
    endfunction

    // pattern bit i, MSB of byte 0 first
    function automatic logic pattern_bit(int unsigned i);
        return pattern_bytes[i / 8][7 - (i % 8)];
    endfunction

    task automatic track_request(input bapc_pkg::op_t op, input logic [7:0] value);
        int unsigned   len;
        int unsigned   hits;
        int unsigned   tail;
        bit            ok;
        logic [COUNT_W:0] sum;
        count_result_t res;
        case (op)
            bapc_pkg::OP_LOAD_PATTERN:
            begin
                if (pattern_ptr < PAT_BYTES)
                begin
                    pattern_bytes[pattern_ptr] = value;
                    pattern_ptr++;
                end
            end
            bapc_pkg::OP_CLEAR_TEXT:
            begin
                text_window      = '0;
                bits_seen        = 0;
                occurrence_total = '0;
            end
            bapc_pkg::OP_CLEAR_PATTERN:
            begin
                foreach (pattern_bytes[k])
                begin
                    pattern_bytes[k] = 8'h00;
                end
                pattern_ptr = 0;
            end
            bapc_pkg::OP_TEXT:
            begin
                text_window = {text_window[HIST_BITS-9:0], value};
                len  = active_length();
                hits = 0;
                // window j ends at bit 7-j of the new byte
                for (int j = 0; j < 8; j++)
                begin
                    if (bits_seen + j + 1 >= len)
                    begin
                        tail = 7 - j;
                        ok   = 1'b1;
                        for (int i = 0; i < len; i++)
                        begin
                            if (text_window[tail + len - 1 - i] != pattern_bit(i))
                            begin
                                ok = 1'b0;
                            end
                        end
                        hits += ok;
                    end
                end
                bits_seen = (bits_seen + 8 > PATTERN_MAX_BITS) ? PATTERN_MAX_BITS
                                                                : bits_seen + 8;
                sum = {1'b0, occurrence_total} + (COUNT_W+1)'(hits);
                occurrence_total = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
                res.hits  = HITS_WIDTH'(hits);
                res.total = occurrence_total;
                pending_counts.push_back(res);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request and config drivers; called at a falling edge, return at one
    // ------------------------------------------------------------------
    task automatic send_request(input bapc_pkg::op_t op, input logic [7:0] value);
        int unsigned gap;
        if (sender_idles && !quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        // loads past a full store are dropped and do not count
        if (!(op == bapc_pkg::OP_LOAD_PATTERN && pattern_ptr >= PAT_BYTES))
        begin
            random_items++;
        end
        if (op == bapc_pkg::OP_TEXT)
        begin
            text_sent++;
        end
        track_request(op, value);
        @(negedge clk);
    endtask

    task automatic write_length(input logic [LEN_WIDTH-1:0] len);
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge clk); while (!cfg_ready);
        length_reg = len;
        length_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random phase: maybe set a length and load a pattern, then stream text,
    // mostly with the pattern embedded at random bit offsets
    // ------------------------------------------------------------------
    task automatic run_phase();
        int unsigned   eff;
        int unsigned   nbytes;
        int unsigned   extra;
        int unsigned   copies;
        int unsigned   noise_len;
        int unsigned   flip_at;
        int unsigned   fill_mode;
        bit            near_miss;
        bit            stream_bits [$];
        logic [7:0]    fill;
        logic [7:0]    b;
        bapc_pkg::op_t stray;

        phases++;
        if ($urandom_range(0, 7) != 0)
        begin
            case ($urandom_range(0, 5))
                0: write_length(LEN_WIDTH'(MIN_LEN));
                1: write_length(LEN_WIDTH'(PATTERN_MAX_BITS));
                2: write_length(LEN_WIDTH'($urandom_range(0, MIN_LEN - 1)));
                3: write_length(LEN_WIDTH'($urandom_range(PATTERN_MAX_BITS + 1, 511)));
                4: write_length(LEN_WIDTH'($urandom_range(MIN_LEN, 40)));
                default: write_length(LEN_WIDTH'($urandom_range(MIN_LEN, PATTERN_MAX_BITS)));
            endcase
        end
        eff    = active_length();
        nbytes = (eff + 7) / 8;

        if ($urandom_range(0, 5) != 0)
        begin
            send_request(bapc_pkg::OP_CLEAR_PATTERN, 8'($urandom_range(0, 255)));
            extra = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PAT_BYTES + 2 - nbytes)
                                                 : 0;
            // periodic patterns give overlapping matches
            fill_mode = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0: fill = 8'h00;
                1: fill = 8'hFF;
                2: fill = 8'hAA;
                default: fill = 8'h55;
            endcase
            for (int k = 0; k < nbytes + extra; k++)
            begin
                send_request(bapc_pkg::OP_LOAD_PATTERN,
                             (fill_mode == 0) ? fill : 8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 3) != 0)
        begin
            send_request(bapc_pkg::OP_CLEAR_TEXT, 8'($urandom_range(0, 255)));
        end

        if ($urandom_range(0, 5) == 0)
        begin
            // plain noise text
            repeat ($urandom_range(4, 24))
            begin
                for (int k = 0; k < 8; k++)
                begin
                    stream_bits.push_back(1'($urandom_range(0, 1)));
                end
            end
        end
        else
        begin
            copies = $urandom_range(1, (eff > 128) ? 2 : 4);
            repeat (copies)
            begin
                noise_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                repeat (noise_len)
                begin
                    stream_bits.push_back(1'($urandom_range(0, 1)));
                end
                near_miss = ($urandom_range(0, 3) == 0);
                flip_at   = $urandom_range(0, eff - 1);
                for (int i = 0; i < eff; i++)
                begin
                    stream_bits.push_back(pattern_bit(i) ^ (near_miss && i == flip_at));
                end
            end
        end
        while (stream_bits.size() % 8 != 0)
        begin
            stream_bits.push_back(1'($urandom_range(0, 1)));
        end

        while (stream_bits.size() != 0)
        begin
            for (int k = 7; k >= 0; k--)
            begin
                b[k] = stream_bits.pop_front();
            end
            if ($urandom_range(0, 39) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: stray = bapc_pkg::OP_LOAD_PATTERN;
                    1: stray = bapc_pkg::OP_CLEAR_TEXT;
                    default: stray = bapc_pkg::OP_CLEAR_PATTERN;
                endcase
                send_request(stray, 8'($urandom_range(0, 255)));
            end
            send_request(bapc_pkg::OP_TEXT, b);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, check against oldest expectation
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (receiver_idles && !quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        count_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_counts.size() == 0)
            begin
                $error("unexpected result: matches_in_byte %0d total_matches %0d",
                       m_tdata[3:0], m_tdata[COUNT_W+3:4]);
                mismatches++;
            end
            else
            begin
                want = pending_counts.pop_front();
                matches_seen += m_tdata[3:0];
                if (m_tdata[3:0] !== want.hits)
                begin
                    $error("matches_in_byte: expected %0d, got %0d",
                           want.hits, m_tdata[3:0]);
                    mismatches++;
                end
                if (m_tdata[COUNT_W+3:4] !== want.total)
                begin
                    $error("total_matches: expected %0d, got %0d",
                           want.total, m_tdata[COUNT_W+3:4]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        stall_left     = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        quiet          = 1'b0;
        cycle_count    = 0;
        mismatches     = 0;
        text_sent      = 0;
        matches_seen   = 0;
        length_writes  = 0;
        phases         = 0;

        // reset image of the predictor
        foreach (pattern_bytes[k])
        begin
            pattern_bytes[k] = 8'h00;
        end
        pattern_ptr      = 0;
        text_window      = '0;
        bits_seen        = 0;
        occurrence_total = '0;
        length_reg       = bapc_pkg::LEN_RESET;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                write_length(LEN_WIDTH'(directed_rows[r].value));
            end
            else
            begin
                send_request(directed_rows[r].op, 8'(directed_rows[r].value));
                if (directed_rows[r].fixed)
                begin
                    pending_counts[$].hits  = directed_rows[r].hits;
                    pending_counts[$].total = directed_rows[r].total;
                end
            end
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            quiet          = (random_items >= QUIET_AFTER);
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            run_phase();
        end

        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES * 2) @(negedge clk);

        $display("Covered %0d text bytes in %0d phases, %0d length writes, %0d matches seen.",
                 text_sent, phases, length_writes, matches_seen);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
